FILE: hdl/ptrb_pkg.sv
// Package for the paper tape RIM/BIN loader.
// Holds the parser state encoding, event codes, state and result structs.
// No dependencies; compile first.

package ptrb_pkg;

	localparam logic [5:0]  OP_DIO    = 6'o32;
	localparam logic [5:0]  OP_JMP    = 6'o60;
	localparam logic [7:0]  STOP_CHAR = 8'o377;
	localparam int unsigned PUNCH_BIT = 7;

	typedef enum logic [1:0] {
		CL_ONE   = 2'd1,
		CL_TWO   = 2'd2,
		CL_THREE = 2'd3
	} chars_left_t;

	typedef enum logic [7:0] {
		PS_START    = 8'b0000_0001,
		PS_RESTART  = 8'b0000_0010,
		PS_LOOKING  = 8'b0000_0100,
		PS_RIM      = 8'b0000_1000,
		PS_RIM_DATA = 8'b0001_0000,
		PS_BIN_END  = 8'b0010_0000,
		PS_BIN      = 8'b0100_0000,
		PS_BIN_SUM  = 8'b1000_0000
	} parse_state_t;

	typedef enum logic [3:0] {
		K_LOAD      = 4'd0,
		K_START     = 4'd1,
		K_RIM_END   = 4'd2,
		K_STRAY     = 4'd3,
		K_SUM_OK    = 4'd4,
		K_SUM_BAD   = 4'd5,
		K_BAD_RIM   = 4'd6,
		K_BAD_BIN   = 4'd7,
		K_CLEAN_END = 4'd8,
		K_MID_END   = 4'd9,
		K_BLOCK_END = 4'd10
	} kind_t;

	// Loader state apart from the load address, whose width is a top-level parameter.
	typedef struct packed {
		logic [17:0]  word_shift;
		chars_left_t  chars_left;
		logic         last_was_stop;
		parse_state_t parse_state;
		logic [11:0]  block_end;
		logic [30:0]  sum;
		logic         halted;
	} state_t;

	localparam state_t STATE_RESET = '{
		word_shift:    18'd0,
		chars_left:    CL_THREE,
		last_was_stop: 1'b0,
		parse_state:   PS_START,
		block_end:     12'd0,
		sum:           31'd0,
		halted:        1'b0
	};

	typedef struct packed {
		logic        valid;
		kind_t       kind;
		logic [11:0] address;
		logic [17:0] data;
	} result_t;

endpackage

FILE: hdl/ptrb_tape_if.sv
// Input channel interface of the loader: one tape character or end-of-tape mark.
// No dependencies.

interface ptrb_tape_if;
	logic       valid;
	logic       ready;
	logic [7:0] tape_char;
	logic       end_of_tape;

	modport source (output valid, output tape_char, output end_of_tape, input ready);
	modport sink (input valid, input tape_char, input end_of_tape, output ready);
endinterface

FILE: hdl/ptrb_evt_if.sv
// Output channel interface of the loader: one load, status or error event.
// No dependencies.

interface ptrb_evt_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [11:0] address;
	logic [17:0] data;

	modport source (output valid, output kind, output address, output data, input ready);
	modport sink (input valid, input kind, input address, input data, output ready);
endinterface

FILE: hdl/ptrb_step.sv
// Next-state and event logic for one tape character of the loader.
// Purely combinational; depends on ptrb_pkg.

module ptrb_step #(
	parameter int unsigned ADDR_BITS = 12
) (
	input  ptrb_pkg::state_t  cur,
	input  logic [ADDR_BITS:0] load_cur,
	input  logic [7:0]         tape_char,
	input  logic               end_of_tape,
	output ptrb_pkg::state_t  nxt,
	output logic [ADDR_BITS:0] load_nxt,
	output ptrb_pkg::result_t res
);
	import ptrb_pkg::*;

	logic [17:0]        word;
	logic [5:0]         op;
	logic [11:0]        operand;
	logic [ADDR_BITS:0] operand_ext;
	logic [ADDR_BITS:0] load_inc;
	logic [ADDR_BITS:0] block_end_ext;
	logic [30:0]        sum_plus;
	logic [12:0]        sum_hi;
	logic [18:0]        fold_a;
	logic [17:0]        fold_sum;
	logic               boundary;

	assign word          = {cur.word_shift[11:0], tape_char[5:0]};
	assign op            = word[17:12];
	assign operand       = word[11:0];
	assign operand_ext   = {{(ADDR_BITS - 11){1'b0}}, operand};
	assign block_end_ext = {{(ADDR_BITS - 11){1'b0}}, cur.block_end};
	assign load_inc      = load_cur + {{ADDR_BITS{1'b0}}, 1'b1};
	assign sum_plus      = cur.sum + {13'd0, word};

	// Ones' complement fold: add the high part back in, then the end-around carry.
	assign sum_hi   = cur.sum[30:18];
	assign fold_a   = (sum_hi != 13'd0) ? ({1'b0, cur.sum[17:0]} + {6'd0, sum_hi})
	                                    : {1'b0, cur.sum[17:0]};
	assign fold_sum = fold_a[18] ? (fold_a[17:0] + 18'd1) : fold_a[17:0];

	// A single stop character before the end of tape still counts as a word boundary.
	assign boundary = (cur.chars_left == CL_THREE) ||
	                  ((cur.chars_left == CL_TWO) && cur.last_was_stop);

	always_comb begin
		nxt         = cur;
		load_nxt    = load_cur;
		res.valid   = 1'b0;
		res.kind    = K_LOAD;
		res.address = 12'd0;
		res.data    = 18'd0;

		if (!cur.halted) begin
			if (end_of_tape) begin
				res.valid = 1'b1;
				if (!boundary) begin
					nxt.halted = 1'b1;
					res.kind   = K_MID_END;
				end else if (cur.parse_state inside {PS_BIN_END, PS_BIN, PS_BIN_SUM}) begin
					nxt.halted = 1'b1;
					res.kind   = K_BLOCK_END;
				end else begin
					nxt      = STATE_RESET;
					load_nxt = '0;
					res.kind = K_CLEAN_END;
				end
			end else if (tape_char[PUNCH_BIT]) begin
				nxt.last_was_stop = (tape_char == STOP_CHAR);
				if (cur.chars_left == CL_THREE || cur.chars_left == CL_TWO) begin
					nxt.word_shift = word;
					nxt.chars_left = (cur.chars_left == CL_THREE) ? CL_TWO : CL_ONE;
				end else begin
					nxt.word_shift = 18'd0;
					nxt.chars_left = CL_THREE;
					case (cur.parse_state)
						PS_RIM_DATA: begin
							nxt.parse_state = PS_RIM;
							res.valid       = 1'b1;
							res.kind        = K_LOAD;
							res.address     = load_cur[11:0];
							res.data        = word;
						end
						PS_RIM: begin
							if (op == OP_JMP) begin
								nxt.parse_state = PS_LOOKING;
								res.valid       = 1'b1;
								res.kind        = K_RIM_END;
								res.address     = operand;
							end else if (op == OP_DIO) begin
								load_nxt        = operand_ext;
								nxt.parse_state = PS_RIM_DATA;
							end else begin
								nxt.halted = 1'b1;
								res.valid  = 1'b1;
								res.kind   = K_BAD_RIM;
								res.data   = word;
							end
						end
						PS_LOOKING: begin
							if (op == OP_DIO) begin
								load_nxt        = operand_ext;
								nxt.sum         = {13'd0, word};
								nxt.parse_state = PS_BIN_END;
							end else if (op == OP_JMP) begin
								nxt.parse_state = PS_RESTART;
								res.valid       = 1'b1;
								res.kind        = K_START;
								res.address     = operand;
							end else begin
								res.valid = 1'b1;
								res.kind  = K_STRAY;
								res.data  = word;
							end
						end
						PS_BIN_END: begin
							if (op != OP_DIO) begin
								nxt.halted = 1'b1;
								res.valid  = 1'b1;
								res.kind   = K_BAD_BIN;
								res.data   = word;
							end else begin
								nxt.sum         = sum_plus;
								nxt.block_end   = operand;
								nxt.parse_state = PS_BIN;
							end
						end
						PS_BIN: begin
							nxt.sum     = sum_plus;
							load_nxt    = load_inc;
							res.valid   = 1'b1;
							res.kind    = K_LOAD;
							res.address = load_cur[11:0];
							res.data    = word;
							if (load_inc >= block_end_ext) begin
								nxt.parse_state = PS_BIN_SUM;
							end
						end
						PS_BIN_SUM: begin
							nxt.parse_state = PS_LOOKING;
							res.valid       = 1'b1;
							res.kind        = (fold_sum == word) ? K_SUM_OK : K_SUM_BAD;
							res.data        = word;
						end
						default: begin
							// Start and restart, and any code that is not a state.
							if (op == OP_DIO) begin
								load_nxt        = operand_ext;
								nxt.parse_state = PS_RIM_DATA;
							end else begin
								res.valid = 1'b1;
								res.kind  = K_STRAY;
								res.data  = word;
							end
						end
					endcase
				end
			end
		end
	end

endmodule

FILE: hdl/paper_tape_rim_bin_loader.sv
// Top level of the paper tape RIM/BIN loader: input stage, loader state, event register.
// Depends on ptrb_pkg, ptrb_tape_if, ptrb_evt_if and ptrb_step.
//
//   channel  modport  direction  payload
//   tape     sink     in         tape_char[7:0], end_of_tape
//   evt      source   out        kind[3:0], address[11:0], data[17:0]
//
// One tape transfer per cycle while evt is not stalled; each transfer is registered
// in the input stage, and its event is then registered in the event register and
// presented on evt. The rate is set by the loader state update between the input stage
// and the event register. Reset returns the loader to its start state at once.
// A stalled event holds in its register while one further character waits in
// the input stage.

module paper_tape_rim_bin_loader #(
	parameter int unsigned ADDR_BITS = 12
) (
	input logic        clk,
	input logic        arst_n,
	ptrb_tape_if.sink  tape,
	ptrb_evt_if.source evt
);
	import ptrb_pkg::*;

	logic               valid_s1;
	logic [7:0]         tape_char_s1;
	logic               eot_s1;
	state_t             st_q;
	state_t             st_nxt;
	logic [ADDR_BITS:0] load_addr_q;
	logic [ADDR_BITS:0] load_addr_nxt;
	result_t            res;
	logic               out_valid_q;
	kind_t              kind_q;
	logic [11:0]        address_q;
	logic [17:0]        data_q;
	logic               res_free;
	logic               proc;

	assign res_free   = !out_valid_q || evt.ready;
	assign proc       = valid_s1 && res_free;
	assign tape.ready = !valid_s1 || res_free;

	ptrb_step #(
		.ADDR_BITS (ADDR_BITS)
	) u_step (
		.cur         (st_q),
		.load_cur    (load_addr_q),
		.tape_char   (tape_char_s1),
		.end_of_tape (eot_s1),
		.nxt         (st_nxt),
		.load_nxt    (load_addr_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			st_q        <= STATE_RESET;
			load_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (tape.ready) begin
				valid_s1 <= tape.valid;
			end
			if (proc) begin
				st_q        <= st_nxt;
				load_addr_q <= load_addr_nxt;
			end
			if (res_free) begin
				out_valid_q <= proc && res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tape.ready && tape.valid) begin
			tape_char_s1 <= tape.tape_char;
			eot_s1       <= tape.end_of_tape;
		end
		if (proc && res.valid) begin
			kind_q    <= res.kind;
			address_q <= res.address;
			data_q    <= res.data;
		end
	end

	assign evt.valid   = out_valid_q;
	assign evt.kind    = kind_q;
	assign evt.address = address_q;
	assign evt.data    = data_q;

	// Once halted, only reset brings the loader back.
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.halted |=> st_q.halted)
		else $error("loader left the halted state without reset");

	// Every halt is announced by an error event in the same transfer.
	a_halt_reported: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(st_q.halted) |-> out_valid_q &&
			(kind_q == K_BAD_RIM || kind_q == K_BAD_BIN ||
			 kind_q == K_MID_END || kind_q == K_BLOCK_END))
		else $error("loader halted without an error event");

	// At a full word boundary (three characters left) the assembly register is empty.
	a_word_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.chars_left == CL_THREE) |-> (st_q.word_shift == 18'd0))
		else $error("word register not cleared at a word boundary");

endmodule
